// ===== rtl/bc_pkg.sv =====
`timescale 1ns / 1ps

package bc_pkg;

  localparam int TOTAL_W      = 6;
  localparam int VALUE_W      = 57;
  // product of the running value and a 6-bit factor
  localparam int PROD_W       = VALUE_W + TOTAL_W;
  // quotient bits retired per divide cycle
  localparam int DIG_W        = 9;
  localparam int DIV_STEPS    = PROD_W / DIG_W;
  localparam int CNT_W        = $clog2(DIV_STEPS);
  localparam int BC_MAX_TOTAL = 60;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_WAIT,
    ST_DONE
  } bc_state_e;

  typedef enum logic {
    U_IDLE,
    U_DIV
  } bc_unit_state_e;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] acc;
    logic [TOTAL_W-1:0] mul;
    logic [TOTAL_W-1:0] div;
  } bc_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] quo;
  } bc_rsp_t;

endpackage

// ===== rtl/bc_muldiv.sv =====
`timescale 1ns / 1ps

// acc * mul / div, divide exact; the multiply is combinational and loaded on start,
// then DIV_STEPS divide steps of DIG_W restoring quotient bits each.
module bc_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bc_pkg::bc_req_t  req_i,
  output bc_pkg::bc_rsp_t  rsp_o
);
  import bc_pkg::*;

  localparam logic [CNT_W-1:0] LastCnt = CNT_W'(DIV_STEPS - 1);

  bc_unit_state_e     ust_q, ust_d;
  logic [PROD_W-1:0]  dvd_q, dvd_d, dvd_nx;
  logic [TOTAL_W-1:0] rem_q, rem_d, rem_nx;
  logic [TOTAL_W-1:0] div_q, div_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0]  prod;

  assign prod = PROD_W'(req_i.acc) * PROD_W'(req_i.mul);

  // DIG_W restoring steps; quotient bits shift in at the bottom
  always_comb begin
    logic [TOTAL_W:0]   t;
    logic [TOTAL_W-1:0] r;
    logic [PROD_W-1:0]  d;
    r = rem_q;
    d = dvd_q;
    for (int b = 0; b < DIG_W; b++) begin
      t = {r, d[PROD_W-1]};
      d = {d[PROD_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        d[0] = 1'b1;
        r    = TOTAL_W'(t - {1'b0, div_q});
      end else begin
        r    = t[TOTAL_W-1:0];
      end
    end
    dvd_nx = d;
    rem_nx = r;
  end

  always_comb begin
    ust_d = ust_q;
    case (ust_q)
      U_IDLE: if (req_i.start) ust_d = U_DIV;
      U_DIV:  if (cnt_q == LastCnt) ust_d = U_IDLE;
      default: ust_d = U_IDLE;
    endcase
  end

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    case (ust_q)
      U_IDLE: begin
        if (req_i.start) begin
          dvd_d = prod;
          rem_d = '0;
          div_d = req_i.div;
          cnt_d = '0;
        end
      end
      U_DIV: begin
        dvd_d = dvd_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ust_q <= U_IDLE;
      cnt_q <= '0;
    end else begin
      ust_q <= ust_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.busy = (ust_q == U_DIV);
  assign rsp_o.done = (ust_q == U_DIV) && (cnt_q == LastCnt);
  assign rsp_o.quo  = dvd_nx[VALUE_W-1:0];

endmodule

// ===== rtl/binomial_coefficient_core.sv =====
`timescale 1ns / 1ps
// Binomial coefficient C(total, choose), one item at a time.
// Each item takes min(choose, total - choose) factor steps on the shared
// multiply/divide unit; the trivial cases (range error, choose above total,
// result one) go straight to done. A new item is taken only once the last
// has moved into the output register. Async active-low reset clears control.
module binomial_coefficient_core #(
  parameter int MAX_TOTAL = bc_pkg::BC_MAX_TOTAL
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bc_pkg::TOTAL_W-1:0]  total_i,
  input  logic [bc_pkg::TOTAL_W-1:0]  choose_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bc_pkg::VALUE_W-1:0]  value_o,
  output logic                        range_error_o
);
  import bc_pkg::*;

  localparam logic [TOTAL_W-1:0] MaxTotal = TOTAL_W'(MAX_TOTAL);

  bc_state_e          state_q, state_d;
  logic [VALUE_W-1:0] acc_q, acc_d;     // running value, C(total, j-1)
  logic               err_q, err_d;
  logic [TOTAL_W-1:0] i_q, i_d;         // falling factor
  logic [TOTAL_W-1:0] j_q, j_d;         // rising divisor
  logic [TOTAL_W-1:0] kk_q, kk_d;       // reduced choose
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic               out_err_q, out_err_d;

  logic               in_acc;
  logic               out_load;
  logic [TOTAL_W-1:0] diff;
  logic [TOTAL_W-1:0] kmin;
  bc_req_t            req;
  bc_rsp_t            rsp;

  bc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  // output register frees up when empty or being taken this cycle
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign diff     = total_i - choose_i;
  assign kmin     = (diff < choose_i) ? diff : choose_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (total_i > MaxTotal || choose_i > total_i || kmin == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: state_d = ST_WAIT;
      ST_WAIT: begin
        if (rsp.done) state_d = (j_q == kk_q) ? ST_DONE : ST_STEP;
      end
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake and unit request
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    req.start  = (state_q == ST_STEP);
    req.acc    = acc_q;
    req.mul    = i_q;
    req.div    = j_q;
  end

  // datapath
  always_comb begin
    acc_d       = acc_q;
    err_d       = err_q;
    i_d         = i_q;
    j_d         = j_q;
    kk_d        = kk_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;
    if (in_acc) begin
      i_d  = total_i;
      j_d  = TOTAL_W'(1);
      kk_d = kmin;
      if (total_i > MaxTotal) begin
        acc_d = '0;
        err_d = 1'b1;
      end else if (choose_i > total_i) begin
        acc_d = '0;
        err_d = 1'b0;
      end else begin
        acc_d = VALUE_W'(1);
        err_d = 1'b0;
      end
    end
    if (state_q == ST_WAIT && rsp.done) begin
      acc_d = rsp.quo;
      i_d   = i_q - TOTAL_W'(1);
      j_d   = j_q + TOTAL_W'(1);
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_value_d = acc_q;
      out_err_d   = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    err_q       <= err_d;
    i_q         <= i_d;
    j_q         <= j_d;
    kk_q        <= kk_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_value_q;
  assign range_error_o = out_err_q;

  // range error always comes with a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (value_o == '0))
    else $error("range error item with non-zero value");

  // unit is never restarted mid-division
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !rsp.busy)
    else $error("divide unit started while busy");

  // a finished division is only seen while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == ST_WAIT))
    else $error("divide result outside wait state");

  // divisor never passes the reduced choose
  a_j_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (j_q <= kk_q && j_q != '0))
    else $error("divisor out of range");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bc_pkg::*;

  // One expected result, kept with the pair that caused it for the reports
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] choose;
    logic [VALUE_W-1:0] value;
    logic               range_error;
  } binom_result_t;

  class binom_scoreboard;
    binom_result_t expected_q[$];
    int unsigned   n_items;
    int unsigned   n_checked;
    int unsigned   n_fail;
    int unsigned   n_range;
    int unsigned   n_zero;

    // running product acc = acc * i / j, exact at every step
    function logic [VALUE_W-1:0] coeff(logic [TOTAL_W-1:0] n,
                                       logic [TOTAL_W-1:0] k);
      logic [63:0]        acc;
      logic [63:0]        i;
      logic [63:0]        j;
      logic [TOTAL_W-1:0] kk;
      if (k > n) return '0;
      kk  = (n - k < k) ? n - k : k;
      acc = 64'd1;
      i   = 64'(n);
      for (j = 64'd1; j <= 64'(kk); j++) begin
        acc = (acc * i) / j;
        i--;
      end
      return acc[VALUE_W-1:0];
    endfunction

    function void note_item(logic [TOTAL_W-1:0] total, logic [TOTAL_W-1:0] choose);
      binom_result_t r;
      r.total  = total;
      r.choose = choose;
      if (total > TOTAL_W'(BC_MAX_TOTAL)) begin
        r.value       = '0;
        r.range_error = 1'b1;
        n_range++;
      end else begin
        r.value       = coeff(total, choose);
        r.range_error = 1'b0;
      end
      if (r.value == '0) n_zero++;
      expected_q.insert(expected_q.size(), r);
      n_items++;
    endfunction

    function void check_result(logic [VALUE_W-1:0] value, logic range_error);
      binom_result_t r;
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("tb: result with nothing pending: value=%0d range_error=%0b",
                   value, range_error);
        return;
      end
      r = expected_q.pop_front();
      n_checked++;
      if (value !== r.value || range_error !== r.range_error) begin
        n_fail++;
        if (n_fail <= 10)
          $display({"tb: C(%0d,%0d) expected value=%0d range_error=%0b, ",
                    "got value=%0d range_error=%0b"},
                   r.total, r.choose, r.value, r.range_error, value, range_error);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int unsigned RANDOM_ITEMS = 1530;
  localparam int unsigned HOLD_CYCLES  = 400;   // well past the worst latency
  localparam int unsigned SETTLE       = 300;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [TOTAL_W-1:0] total_i     = '0;
  logic [TOTAL_W-1:0] choose_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [VALUE_W-1:0] value_o;
  logic               range_error_o;

  // directed pairs
  logic [TOTAL_W-1:0] d_total[23]  = '{0, 0, 1, 1, 2, 5, 20, 42, 31, 59, 60, 60,
                                       60, 60, 60, 60, 60, 60, 61, 61, 62, 63, 63};
  logic [TOTAL_W-1:0] d_choose[23] = '{0, 1, 0, 1, 1, 63, 10, 21, 32, 30, 0, 1,
                                       29, 30, 31, 59, 60, 61, 0, 30, 63, 0, 63};

  binom_scoreboard sb = new();

  // steady: no idling on either side; hold_req/hold_seen: receiver hold-offs
  bit          steady    = 1'b0;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle;

  binomial_coefficient_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .total_i       (total_i),
    .choose_i      (choose_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .range_error_o (range_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one item and return at the edge that takes it. Valid is only
  // lowered for a gap, so back-to-back items keep it high without a glitch.
  task automatic offer_item(input logic [TOTAL_W-1:0] total,
                            input logic [TOTAL_W-1:0] choose);
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      // now and then a long gap so the next item lands mid-computation
      if ($urandom_range(0, 99) < 4) gap = $urandom_range(20, 250);
      else while ($urandom_range(0, 99) < 37) gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    total_i    <= total;
    choose_i   <= choose;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(total, choose);
  endtask

  // Sender pause: valid low until every pending result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: take what the block presents, then pick the next stall.
  // Values are sampled before this edge's updates land.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && !out_stall_i)
      sb.check_result(value_o, range_error_o);
    if (hold_seen < hold_req) begin
      hold_seen++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 37);
    end
  end

  initial begin
    for (cycle = 0; cycle < CYCLE_LIMIT; cycle++) @(posedge clk_i);
    $display("tb: timed out with %0d results pending", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [TOTAL_W-1:0] t;
    logic [TOTAL_W-1:0] c;
    int unsigned        r;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty and full choose, choose above total, the widest
    // coefficient C(60,30) and its neighbours, every out-of-range total.
    foreach (d_total[n]) offer_item(d_total[n], d_choose[n]);
    drain();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // receiver holds off long enough for the block to stall its input
      if (n == 300 || n == 1300) hold_req++;
      if (n == 800) drain();
      steady = (n >= 1000 && n < 1200);

      // mostly in-range pairs with choose <= total, where the real work is
      r = $urandom_range(0, 99);
      if (r < 60) begin
        t = TOTAL_W'($urandom_range(0, BC_MAX_TOTAL));
        c = TOTAL_W'($urandom_range(0, 32'(t)));
      end else if (r < 85) begin
        t = TOTAL_W'($urandom_range(0, 63));
        c = TOTAL_W'($urandom_range(0, 63));
      end else begin
        t = TOTAL_W'($urandom_range(BC_MAX_TOTAL + 1, 63));
        c = TOTAL_W'($urandom_range(0, 63));
      end
      offer_item(t, c);
    end

    drain();
    // catch anything the block emits beyond what was asked for
    repeat (SETTLE) @(posedge clk_i);

    $display("tb: %0d pairs checked, %0d out of range, %0d zero coefficients",
             sb.n_checked, sb.n_range, sb.n_zero);
    $display("tb: %0d receiver hold-offs, %0d failures", hold_seen, sb.n_fail);
    if (sb.n_fail == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
